@@ hw/rtl/dtv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtv_pkg
// Types, codes and fixed-point constants shared by the top-view map block.
// ----------------------------------------------------------------------------
package dtv_pkg;

  localparam int DW          = 26;  // depth in mm, Q12, bounded by max range
  localparam int AQW         = 31;  // Q30 angle and series terms
  localparam int LATW        = 27;  // lateral distance, Q12
  localparam int DIVW        = 27;  // divisor and partial remainder
  localparam int RECIP_SHIFT = 24;

  localparam logic [AQW-1:0] PI3_Q30 = 31'd1124419809;
  localparam logic [AQW-1:0] C3_Q30  = 31'd357913941;
  localparam logic [AQW-1:0] C5_Q30  = 31'd143165577;
  localparam logic [AQW-1:0] C7_Q30  = 31'd57947971;
  localparam logic [AQW-1:0] C9_Q30  = 31'd23482185;
  localparam logic [AQW-1:0] C11_Q30 = 31'd9516827;
  localparam logic [AQW-1:0] ONE_Q30 = 31'd1073741824;

  localparam logic [15:0] SCALE_RST = 16'd4096;
  localparam logic [13:0] MAX_RST   = 14'd4000;
  localparam logic [13:0] MIN_RST   = 14'd200;
  localparam logic [10:0] WIDTH_RST = 11'd640;

  localparam logic [23:0] COLOR_WHITE  = {8'd255, 8'd255, 8'd255};
  localparam logic [23:0] COLOR_ROBOT  = {8'd0, 8'd255, 8'd0};
  localparam logic [23:0] COLOR_CENTRE = {8'd255, 8'd0, 8'd0};
  localparam logic [23:0] COLOR_GRID   = {8'd200, 8'd200, 8'd200};

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_MAX   = 2'd1,
    REG_MIN   = 2'd2,
    REG_WIDTH = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef struct packed {
    logic [15:0] value_scale;
    logic [13:0] max_range_mm;
    logic [13:0] min_range_mm;
    logic [10:0] frame_cols;
  } cfg_t;

  typedef struct packed {
    op_t           op;
    logic [DW-1:0] depth;
    logic [9:0]    col;
    logic [9:0]    read_x;
    logic [8:0]    read_y;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic keep;
  } geom_stat_t;

  typedef enum logic [3:0] {
    G_IDLE,
    G_DIV_U,
    G_MUL_A,
    G_MUL_A2,
    G_MUL_P,
    G_MUL_T,
    G_MUL_LAT,
    G_DIV_OFF,
    G_DIV_Y,
    G_DIV_C0,
    G_DIV_C2,
    G_DONE
  } geom_state_t;

  typedef enum logic [1:0] {
    B_SWEEP,
    B_IDLE,
    B_SAMPLE,
    B_RESP
  } back_state_t;

  // n is a multiple of d when floor(n * recip / 2^24) * d == n
  function automatic logic is_mult(input logic [9:0] n, input logic [24:0] recip,
                                   input logic [8:0] d);
    logic [34:0] prod;
    logic [9:0]  q;
    logic [18:0] chk;
    prod = 35'(n) * 35'(recip);
    q    = prod[33:24];
    chk  = 19'(q) * 19'(d);
    return chk == 19'(n);
  endfunction

  function automatic logic [AQW-1:0] tan_coef(input logic [2:0] i);
    logic [AQW-1:0] c;
    case (i)
      3'd0:    c = C9_Q30;
      3'd1:    c = C7_Q30;
      3'd2:    c = C5_Q30;
      3'd3:    c = C3_Q30;
      default: c = ONE_Q30;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/dtv_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtv_req_if
// Request channel: clear, depth sample or map pixel read.
// ----------------------------------------------------------------------------
interface dtv_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [9:0] col;
  logic [9:0] row;
  logic [15:0] depth_raw;
  logic [9:0] read_x;
  logic [8:0] read_y;

  modport source (output valid, kind, col, row, depth_raw, read_x, read_y, input ready);
  modport sink   (input valid, kind, col, row, depth_raw, read_x, read_y, output ready);
endinterface

@@ hw/rtl/dtv_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtv_rsp_if
// Response channel: the three colour bytes of one map pixel.
// ----------------------------------------------------------------------------
interface dtv_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;

  modport source (output valid, chan0, chan1, chan2, input ready);
  modport sink   (input valid, chan0, chan1, chan2, output ready);
endinterface

@@ hw/rtl/dtv_csr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtv_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dtv_csr_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/depth_to_top_view_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_top_view_map
// Top-down occupancy map built from subsampled depth samples.
//
// req carries one transaction per clear, depth sample or pixel read; rsp
// returns one pixel (three colour bytes) per read, nothing for the others.
// csr writes the four registers; write them only while the block is idle.
// A sample is projected on one shared multiplier and a one-bit-per-cycle
// divider. A read is registered with its pixel classification on leaving
// the queue, then rendered into the response register. A clear, and reset,
// sweep all MAP_WIDTH * MAP_HEIGHT cells of the point store one cell per
// cycle, with req held not ready. A two-entry command queue lets req run
// ahead of the back end; a read that waits on a stalled rsp holds the head
// of the queue, so every command behind it waits too.
// ----------------------------------------------------------------------------
module depth_to_top_view_map #(
  parameter int MAP_WIDTH    = 640,
  parameter int MAP_HEIGHT   = 480,
  parameter int SAMPLE_STEP  = 4,
  parameter int GRID_SPACING = 50
) (
  input  logic      clk,
  input  logic      rst,
  dtv_req_if.sink   req,
  dtv_rsp_if.source rsp,
  dtv_csr_if.sink   csr
);

  dtv_pkg::cmd_t push_data;
  dtv_pkg::cmd_t pop_data;
  dtv_pkg::cfg_t cfg;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  logic          clearing;

  dtv_front #(
    .SAMPLE_STEP (SAMPLE_STEP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .csr       (csr),
    .q_full    (full),
    .clearing  (clearing),
    .push      (push),
    .push_data (push_data),
    .cfg       (cfg)
  );

  dtv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  dtv_back #(
    .MAP_WIDTH    (MAP_WIDTH),
    .MAP_HEIGHT   (MAP_HEIGHT),
    .GRID_SPACING (GRID_SPACING)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (pop_data),
    .q_empty  (empty),
    .q_pop    (pop),
    .cfg      (cfg),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule

@@ hw/rtl/dtv_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtv_front
// Holds the registers, accepts requests and turns them into commands.
// ----------------------------------------------------------------------------
module dtv_front #(
  parameter int SAMPLE_STEP = 4
) (
  input  logic          clk,
  input  logic          rst,
  dtv_req_if.sink       req,
  dtv_csr_if.sink       csr,
  input  logic          q_full,
  input  logic          clearing,
  output logic          push,
  output dtv_pkg::cmd_t push_data,
  output dtv_pkg::cfg_t cfg
);

  localparam logic [24:0] STEP_RECIP =
    25'(((1 << dtv_pkg::RECIP_SHIFT) + SAMPLE_STEP - 1) / SAMPLE_STEP);
  localparam logic [8:0] STEP_D = 9'(SAMPLE_STEP);

  logic [31:0] depth_q12;
  logic        step_ok;
  logic        sample_ok;
  logic        accept;

  assign csr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.value_scale  <= dtv_pkg::SCALE_RST;
      cfg.max_range_mm <= dtv_pkg::MAX_RST;
      cfg.min_range_mm <= dtv_pkg::MIN_RST;
      cfg.frame_cols   <= dtv_pkg::WIDTH_RST;
    end else if (csr.valid) begin
      case (dtv_pkg::reg_idx_t'(csr.index))
        dtv_pkg::REG_SCALE: cfg.value_scale  <= csr.data;
        dtv_pkg::REG_MAX:   cfg.max_range_mm <= csr.data[13:0];
        dtv_pkg::REG_MIN:   cfg.min_range_mm <= csr.data[13:0];
        dtv_pkg::REG_WIDTH: cfg.frame_cols   <= csr.data[10:0];
        default: ;
      endcase
    end
  end

  assign depth_q12 = 32'(req.depth_raw) * 32'(cfg.value_scale);
  assign step_ok   = dtv_pkg::is_mult(req.col, STEP_RECIP, STEP_D) &&
                     dtv_pkg::is_mult(req.row, STEP_RECIP, STEP_D);
  assign sample_ok = step_ok && (cfg.frame_cols != 11'd0) &&
                     (11'(req.col) < cfg.frame_cols) &&
                     (cfg.max_range_mm != 14'd0) && (req.depth_raw != 16'd0) &&
                     (depth_q12 <= 32'({cfg.max_range_mm, 12'd0})) &&
                     (depth_q12 >= 32'({cfg.min_range_mm, 12'd0}));

  assign req.ready = !q_full && !clearing;
  assign accept    = req.valid && req.ready;

  always_comb begin
    push_data.depth  = depth_q12[dtv_pkg::DW-1:0];
    push_data.col    = req.col;
    push_data.read_x = req.read_x;
    push_data.read_y = req.read_y;
    push_data.op     = dtv_pkg::OP_CLEAR;
    push             = 1'b0;
    case (dtv_pkg::kind_t'(req.kind))
      dtv_pkg::KIND_CLEAR: begin
        push_data.op = dtv_pkg::OP_CLEAR;
        push         = accept;
      end
      dtv_pkg::KIND_SAMPLE: begin
        push_data.op = dtv_pkg::OP_SAMPLE;
        push         = accept && sample_ok;
      end
      dtv_pkg::KIND_READ: begin
        push_data.op = dtv_pkg::OP_READ;
        push         = accept;
      end
      default: push = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/dtv_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtv_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module dtv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dtv_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output dtv_pkg::cmd_t pop_data,
  output logic          empty
);

  dtv_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("command popped from an empty queue");

endmodule

@@ hw/rtl/dtv_geom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtv_geom
// Projects one depth sample to a map cell and its colour, on a shared
// multiplier and a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
module dtv_geom #(
  parameter int MAP_WIDTH  = 640,
  parameter int MAP_HEIGHT = 480
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [dtv_pkg::DW-1:0]                    depth,
  input  logic [9:0]                                col,
  input  dtv_pkg::cfg_t                             cfg,
  output dtv_pkg::geom_stat_t                       stat,
  output logic [$clog2(MAP_WIDTH*MAP_HEIGHT)-1:0]   addr,
  output logic [15:0]                               data
);

  localparam int DW    = dtv_pkg::DW;
  localparam int AQW   = dtv_pkg::AQW;
  localparam int LATW  = dtv_pkg::LATW;
  localparam int DIVW  = dtv_pkg::DIVW;
  localparam int QW    = $clog2(MAP_WIDTH) + 1;
  localparam int QH    = $clog2(MAP_HEIGHT) + 1;
  localparam int AW    = $clog2(MAP_WIDTH * MAP_HEIGHT);
  localparam int OFFW  = LATW + QW;
  localparam int YW    = DW + QH;
  localparam int CW    = DW + 8;
  localparam int HALF_W  = MAP_WIDTH / 2;
  localparam int RHALF_W = MAP_WIDTH - MAP_WIDTH / 2;

  dtv_pkg::geom_state_t state, state_next;

  logic            ph;
  logic [4:0]      cnt;
  logic [2:0]      hc;
  logic            left;
  logic            keep;
  logic [DW-1:0]   depth_q;
  logic [9:0]      col_q;
  logic [15:0]     u;
  logic [AQW-1:0]  a;
  logic [AQW-1:0]  a2;
  logic [AQW-1:0]  p;
  logic [AQW-1:0]  t;
  logic [LATW-1:0] lat;
  logic [QW-1:0]   mx;
  logic [QH-1:0]   my;
  logic [7:0]      c0;
  logic [7:0]      c2;
  logic [61:0]     prod;
  logic [DIVW-1:0] rem;
  logic [DIVW-1:0] dv;
  logic [15:0]     low;
  logic [15:0]     q;

  logic [AQW-1:0]  mul_a;
  logic [AQW-1:0]  mul_b;
  logic [DIVW-1:0] rem0;
  logic [DIVW-1:0] dv0;
  logic [15:0]     low0;
  logic [4:0]      dn;
  logic [DW-1:0]   m_q12;
  logic [11:0]     w12;
  logic [11:0]     col2;
  logic [11:0]     num;
  logic [OFFW-1:0] n_off;
  logic [YW-1:0]   n_y;
  logic [CW-1:0]   n_c0;
  logic [CW-1:0]   n_c2;
  logic [DIVW:0]   trial;
  logic [QW-1:0]   off;
  logic [AW:0]     idx;

  assign m_q12 = {cfg.max_range_mm, 12'd0};
  assign w12   = 12'(cfg.frame_cols);
  assign col2  = {1'b0, col_q, 1'b0};
  assign num   = left ? (w12 - col2) : (col2 - w12);
  assign n_off = OFFW'(lat) * OFFW'(MAP_WIDTH);
  assign n_y   = YW'(depth_q) * YW'(MAP_HEIGHT);
  assign n_c0  = CW'(m_q12 - depth_q) * CW'(200);
  assign n_c2  = CW'(depth_q) * CW'(100);
  assign trial = {rem, low[15]};
  assign off   = q[QW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      dtv_pkg::G_IDLE:    if (start) state_next = dtv_pkg::G_DIV_U;
      dtv_pkg::G_DIV_U:   if (ph && cnt == 5'd0) state_next = dtv_pkg::G_MUL_A;
      dtv_pkg::G_MUL_A:   if (ph) state_next = dtv_pkg::G_MUL_A2;
      dtv_pkg::G_MUL_A2:  if (ph) state_next = dtv_pkg::G_MUL_P;
      dtv_pkg::G_MUL_P:   if (ph && hc == 3'd4) state_next = dtv_pkg::G_MUL_T;
      dtv_pkg::G_MUL_T:   if (ph) state_next = dtv_pkg::G_MUL_LAT;
      dtv_pkg::G_MUL_LAT: if (ph) state_next = dtv_pkg::G_DIV_OFF;
      dtv_pkg::G_DIV_OFF: if (ph && cnt == 5'd0) state_next = dtv_pkg::G_DIV_Y;
      dtv_pkg::G_DIV_Y:   if (ph && cnt == 5'd0) state_next = dtv_pkg::G_DIV_C0;
      dtv_pkg::G_DIV_C0:  if (ph && cnt == 5'd0) state_next = dtv_pkg::G_DIV_C2;
      dtv_pkg::G_DIV_C2:  if (ph && cnt == 5'd0) state_next = dtv_pkg::G_DONE;
      dtv_pkg::G_DONE:    state_next = dtv_pkg::G_IDLE;
      default:            state_next = dtv_pkg::G_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    rem0  = '0;
    dv0   = DIVW'(m_q12);
    low0  = '0;
    dn    = 5'd8;
    stat.done = (state == dtv_pkg::G_DONE);
    stat.keep = keep;
    case (state)
      dtv_pkg::G_DIV_U: begin
        rem0 = DIVW'(num);
        dv0  = DIVW'({cfg.frame_cols, 1'b0});
        dn   = 5'd16;
      end
      dtv_pkg::G_MUL_A: begin
        mul_a = AQW'(u);
        mul_b = dtv_pkg::PI3_Q30;
      end
      dtv_pkg::G_MUL_A2: begin
        mul_a = a;
        mul_b = a;
      end
      dtv_pkg::G_MUL_P: begin
        mul_a = a2;
        mul_b = p;
      end
      dtv_pkg::G_MUL_T: begin
        mul_a = a;
        mul_b = p;
      end
      dtv_pkg::G_MUL_LAT: begin
        mul_a = AQW'(depth_q);
        mul_b = t;
      end
      dtv_pkg::G_DIV_OFF: begin
        rem0 = DIVW'(n_off >> QW);
        low0 = 16'(n_off[QW-1:0]) << (16 - QW);
        dv0  = DIVW'({m_q12, 1'b0});
        dn   = 5'(QW);
      end
      dtv_pkg::G_DIV_Y: begin
        rem0 = DIVW'(n_y >> QH);
        low0 = 16'(n_y[QH-1:0]) << (16 - QH);
        dn   = 5'(QH);
      end
      dtv_pkg::G_DIV_C0: begin
        rem0 = DIVW'(n_c0 >> 8);
        low0 = {n_c0[7:0], 8'd0};
      end
      dtv_pkg::G_DIV_C2: begin
        rem0 = DIVW'(n_c2 >> 8);
        low0 = {n_c2[7:0], 8'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtv_pkg::G_IDLE;
      ph    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dtv_pkg::G_IDLE || state == dtv_pkg::G_DONE) begin
        ph <= 1'b0;
      end else if (!ph) begin
        ph <= 1'b1;
      end else if (state == dtv_pkg::G_DIV_U || state == dtv_pkg::G_DIV_OFF ||
                   state == dtv_pkg::G_DIV_Y || state == dtv_pkg::G_DIV_C0 ||
                   state == dtv_pkg::G_DIV_C2) begin
        if (cnt == 5'd0) ph <= 1'b0;
      end else begin
        ph <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == dtv_pkg::G_IDLE && start) begin
      depth_q <= depth;
      col_q   <= col;
      left    <= 12'({col, 1'b0}) < 12'(cfg.frame_cols);
      keep    <= 1'b1;
      hc      <= 3'd0;
      p       <= dtv_pkg::C11_Q30;
    end
    case (state)
      dtv_pkg::G_DIV_U, dtv_pkg::G_DIV_OFF, dtv_pkg::G_DIV_Y,
      dtv_pkg::G_DIV_C0, dtv_pkg::G_DIV_C2: begin
        if (!ph) begin
          rem <= rem0;
          dv  <= dv0;
          low <= low0;
          cnt <= dn;
          q   <= '0;
        end else if (cnt != 5'd0) begin
          if (trial >= {1'b0, dv}) begin
            rem <= DIVW'(trial - {1'b0, dv});
            q   <= {q[14:0], 1'b1};
          end else begin
            rem <= trial[DIVW-1:0];
            q   <= {q[14:0], 1'b0};
          end
          low <= {low[14:0], 1'b0};
          cnt <= cnt - 5'd1;
        end else begin
          case (state)
            dtv_pkg::G_DIV_U: u <= q;
            dtv_pkg::G_DIV_OFF: begin
              if (left) begin
                if (32'(off) > 32'(HALF_W)) keep <= 1'b0;
                mx <= QW'(HALF_W) - off;
              end else begin
                if (32'(off) >= 32'(RHALF_W)) keep <= 1'b0;
                mx <= QW'(HALF_W) + off;
              end
            end
            dtv_pkg::G_DIV_Y: begin
              my <= q[QH-1:0];
              if (32'(q[QH-1:0]) >= 32'(MAP_HEIGHT)) keep <= 1'b0;
            end
            dtv_pkg::G_DIV_C0: c0 <= q[7:0];
            default:           c2 <= q[7:0];
          endcase
        end
      end
      dtv_pkg::G_MUL_A, dtv_pkg::G_MUL_A2, dtv_pkg::G_MUL_P,
      dtv_pkg::G_MUL_T, dtv_pkg::G_MUL_LAT: begin
        if (!ph) begin
          prod <= 62'(mul_a) * 62'(mul_b);
        end else begin
          case (state)
            dtv_pkg::G_MUL_A:  a  <= prod[46:16];
            dtv_pkg::G_MUL_A2: a2 <= prod[60:30];
            dtv_pkg::G_MUL_P: begin
              p  <= dtv_pkg::tan_coef(hc) + prod[60:30];
              hc <= hc + 3'd1;
            end
            dtv_pkg::G_MUL_T:  t  <= prod[60:30];
            default:           lat <= prod[56:30];
          endcase
        end
      end
      default: ;
    endcase
  end

  assign idx  = (AW + 1)'(my) * (AW + 1)'(MAP_WIDTH) + (AW + 1)'(mx);
  assign addr = idx[AW-1:0];
  assign data = {c0, c2};

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) stat.done |=> !stat.done)
    else $error("projection done held for more than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == dtv_pkg::G_IDLE)
    else $error("projection started while busy");

endmodule

@@ hw/rtl/dtv_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtv_back
// Executes commands: clears the point store, stores projected samples and
// renders map pixels into the response register.
// ----------------------------------------------------------------------------
module dtv_back #(
  parameter int MAP_WIDTH    = 640,
  parameter int MAP_HEIGHT   = 480,
  parameter int GRID_SPACING = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  dtv_pkg::cmd_t q_data,
  input  logic          q_empty,
  output logic          q_pop,
  input  dtv_pkg::cfg_t cfg,
  output logic          clearing,
  dtv_rsp_if.source     rsp
);

  localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [24:0] GRID_RECIP =
    25'(((1 << dtv_pkg::RECIP_SHIFT) + GRID_SPACING - 1) / GRID_SPACING);
  localparam logic [8:0] GRID_D = 9'(GRID_SPACING);

  dtv_pkg::back_state_t state, state_next;

  logic [16:0]   mem [CELLS];
  logic [16:0]   rdata;
  logic [AW-1:0] sweep_cnt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [16:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  logic                 geom_start;
  dtv_pkg::geom_stat_t  geom_stat;
  logic [AW-1:0]        geom_addr;
  logic [15:0]          geom_data;

  logic          out_valid;
  logic [23:0]   out_pix;
  logic [23:0]   pix;
  logic          has_cmd;

  logic              in_map;
  logic signed [12:0] dx;
  logic signed [12:0] dy;
  logic              near;
  logic [2:0]        adx;
  logic [2:0]        ady;
  logic [5:0]        sq;
  logic              disc;
  logic              centre;
  logic              grid;
  logic [AW:0]       ridx;
  logic              in_map_q;
  logic              disc_q;
  logic              centre_q;
  logic              grid_q;

  dtv_geom #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_geom (
    .clk   (clk),
    .rst   (rst),
    .start (geom_start),
    .depth (q_data.depth),
    .col   (q_data.col),
    .cfg   (cfg),
    .stat  (geom_stat),
    .addr  (geom_addr),
    .data  (geom_data)
  );

  assign has_cmd = !q_empty;

  always_comb begin
    state_next = state;
    case (state)
      dtv_pkg::B_SWEEP: if (32'(sweep_cnt) == 32'(CELLS - 1)) state_next = dtv_pkg::B_IDLE;
      dtv_pkg::B_IDLE: begin
        if (has_cmd) begin
          case (q_data.op)
            dtv_pkg::OP_CLEAR:  state_next = dtv_pkg::B_SWEEP;
            dtv_pkg::OP_SAMPLE: state_next = dtv_pkg::B_SAMPLE;
            dtv_pkg::OP_READ:   if (!out_valid) state_next = dtv_pkg::B_RESP;
            default:            state_next = dtv_pkg::B_IDLE;
          endcase
        end
      end
      dtv_pkg::B_SAMPLE: if (geom_stat.done) state_next = dtv_pkg::B_IDLE;
      dtv_pkg::B_RESP:   state_next = dtv_pkg::B_IDLE;
      default:           state_next = dtv_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    clearing   = (state == dtv_pkg::B_SWEEP);
    q_pop      = 1'b0;
    geom_start = 1'b0;
    re         = 1'b0;
    we         = 1'b0;
    waddr      = geom_addr;
    wdata      = {1'b1, geom_data};
    case (state)
      dtv_pkg::B_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_cnt;
        wdata = '0;
      end
      dtv_pkg::B_IDLE: begin
        if (has_cmd) begin
          case (q_data.op)
            dtv_pkg::OP_SAMPLE: begin
              q_pop      = 1'b1;
              geom_start = 1'b1;
            end
            dtv_pkg::OP_READ: begin
              q_pop = !out_valid;
              re    = !out_valid;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      dtv_pkg::B_SAMPLE: we = geom_stat.done && geom_stat.keep;
      default: ;
    endcase
  end

  // pixel classification of the read address
  always_comb begin
    in_map = (12'(q_data.read_x) < 12'(MAP_WIDTH)) && (12'(q_data.read_y) < 12'(MAP_HEIGHT));
    dx     = $signed(13'(q_data.read_x)) - $signed(13'(MAP_WIDTH / 2));
    dy     = $signed(13'(q_data.read_y)) - $signed(13'(MAP_HEIGHT - 10));
    near   = (dx >= -13'sd5) && (dx <= 13'sd5) && (dy >= -13'sd5) && (dy <= 13'sd5);
    adx    = dx[12] ? 3'(-dx) : 3'(dx);
    ady    = dy[12] ? 3'(-dy) : 3'(dy);
    sq     = 6'(adx) * 6'(adx) + 6'(ady) * 6'(ady);
    disc   = near && (sq <= 6'd25);
    centre = (12'(q_data.read_x) == 12'(MAP_WIDTH / 2));
    grid   = dtv_pkg::is_mult(q_data.read_x, GRID_RECIP, GRID_D) ||
             dtv_pkg::is_mult(10'(q_data.read_y), GRID_RECIP, GRID_D);
    ridx   = (AW + 1)'(q_data.read_y) * (AW + 1)'(MAP_WIDTH) + (AW + 1)'(q_data.read_x);
    raddr  = in_map ? ridx[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata    <= mem[raddr];
      in_map_q <= in_map;
      disc_q   <= disc;
      centre_q <= centre;
      grid_q   <= grid;
    end
  end

  always_comb begin
    if (!in_map_q) begin
      pix = dtv_pkg::COLOR_WHITE;
    end else if (disc_q) begin
      pix = dtv_pkg::COLOR_ROBOT;
    end else if (rdata[16]) begin
      pix = {rdata[15:8], 8'd0, rdata[7:0]};
    end else if (centre_q) begin
      pix = dtv_pkg::COLOR_CENTRE;
    end else if (grid_q) begin
      pix = dtv_pkg::COLOR_GRID;
    end else begin
      pix = dtv_pkg::COLOR_WHITE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dtv_pkg::B_SWEEP;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dtv_pkg::B_SWEEP) begin
        sweep_cnt <= sweep_cnt + AW'(1);
      end else begin
        sweep_cnt <= '0;
      end
      if (state == dtv_pkg::B_RESP) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == dtv_pkg::B_RESP) begin
      out_pix <= pix;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.chan0 = out_pix[23:16];
  assign rsp.chan1 = out_pix[15:8];
  assign rsp.chan2 = out_pix[7:0];

  a_resp_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == dtv_pkg::B_RESP |-> !out_valid)
    else $error("pixel rendered while the response register is occupied");
  a_valid_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == dtv_pkg::B_RESP))
    else $error("response raised without a rendered pixel");

endmodule
